// ===== rtl/aar_pkg.sv =====
package aar_pkg;

  localparam int DIM = 4;
  localparam int ELEMS = DIM * DIM;
  localparam int ELEM_W = $clog2(ELEMS);

  localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
  localparam logic signed [35:0] Q30_PI = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI = 36'sd6746518852;
  localparam logic signed [35:0] Q30_FOUR_PI = 36'sd13493037704;
  localparam logic signed [33:0] Q30_GAIN = 34'sd652032875;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               degenerate;
    logic               last;
  } out_t;

  typedef struct packed {
    logic             deg;
    logic [8:0][31:0] rv;
    logic [2:0][31:0] tv;
  } mat_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021687;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048576;
      5'd11: r = 32'd524288;
      5'd12: r = 32'd262144;
      5'd13: r = 32'd131072;
      5'd14: r = 32'd65536;
      5'd15: r = 32'd32768;
      5'd16: r = 32'd16384;
      5'd17: r = 32'd8192;
      5'd18: r = 32'd4096;
      5'd19: r = 32'd2048;
      5'd20: r = 32'd1024;
      5'd21: r = 32'd512;
      5'd22: r = 32'd256;
      5'd23: r = 32'd128;
      5'd24: r = 32'd64;
      5'd25: r = 32'd32;
      5'd26: r = 32'd16;
      5'd27: r = 32'd8;
      5'd28: r = 32'd4;
      5'd29: r = 32'd2;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/aar_pipe.sv =====
module aar_pipe import aar_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  in_t  in_item,
  output logic out_valid,
  output mat_t out_mat
);

  localparam int SQ_K = 5;
  localparam int SUM_K = 6;
  localparam int SQRT0 = 7;
  localparam int DIV0 = 39;
  localparam int NS = 70;
  localparam int RND_SH = 30 - FRAC_BITS;
  localparam logic signed [36:0] RND = 37'sd1 <<< (RND_SH - 1);
  localparam logic signed [55:0] S32_MAX = 56'sd2147483647;
  localparam logic signed [55:0] S32_MIN = -56'sd2147483648;

  typedef struct packed {
    logic                deg;
    logic [2:0]          neg;
    logic [2:0][31:0]    mag;
    logic [2:0][31:0]    cen;
    logic signed [35:0]  th;
    logic                flip;
    logic [2:0][63:0]    sqp;
    logic [63:0]         n;
    logic [35:0]         sr;
    logic [31:0]         sq;
    logic signed [33:0]  cx;
    logic signed [33:0]  cy;
    logic signed [35:0]  cz;
    logic [2:0][31:0]    dr;
    logic [2:0][30:0]    dq;
  } stage_t;

  function automatic logic [31:0] sat32(input logic signed [55:0] v);
    logic [31:0] r;
    if (v > S32_MAX) r = 32'h7fffffff;
    else if (v < S32_MIN) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  stage_t st [NS+1];
  logic   v  [NS+1];
  stage_t cap;

  always_comb begin
    logic [2:0][31:0] a;
    a[0] = in_item.axis_x;
    a[1] = in_item.axis_y;
    a[2] = in_item.axis_z;
    cap = '0;
    for (int i = 0; i < 3; i++) begin
      cap.neg[i] = a[i][31];
      cap.mag[i] = a[i][31] ? (~a[i] + 32'd1) : a[i];
    end
    cap.cen[0] = in_item.center_x;
    cap.cen[1] = in_item.center_y;
    cap.cen[2] = in_item.center_z;
    cap.deg = ((a[0] | a[1] | a[2]) == 32'd0);
    cap.th = {{2{in_item.angle[31]}}, in_item.angle, 2'b00};
    cap.flip = 1'b0;
  end

  always_ff @(posedge clk) begin
    st[0] <= cap;
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    stage_t nx;

    if (k < SQ_K) begin : g_norm
      localparam int SH = 16 >> k;
      always_comb begin
        logic [31:0] orv;
        nx = st[k];
        orv = st[k].mag[0] | st[k].mag[1] | st[k].mag[2];
        if (orv[31 -: (SH + 1)] == '0) begin
          for (int i = 0; i < 3; i++) nx.mag[i] = st[k].mag[i] << SH;
        end
        if (k == 0) begin
          if (st[k].th < -Q30_TWO_PI) nx.th = st[k].th + Q30_FOUR_PI;
          else if (st[k].th < 0) nx.th = st[k].th + Q30_TWO_PI;
          else if (st[k].th >= Q30_TWO_PI) nx.th = st[k].th - Q30_TWO_PI;
        end else if (k == 1) begin
          if (st[k].th > Q30_PI) nx.th = st[k].th - Q30_TWO_PI;
        end else if (k == 2) begin
          if (st[k].th > Q30_HALF_PI) begin
            nx.th = Q30_PI - st[k].th;
            nx.flip = 1'b1;
          end else if (st[k].th < -Q30_HALF_PI) begin
            nx.th = -Q30_PI - st[k].th;
            nx.flip = 1'b1;
          end
        end
      end
    end else if (k == SQ_K) begin : g_sq
      always_comb begin
        nx = st[k];
        for (int i = 0; i < 3; i++) begin
          nx.sqp[i] = {32'd0, st[k].mag[i]} * {32'd0, st[k].mag[i]};
        end
      end
    end else if (k == SUM_K) begin : g_sum
      always_comb begin
        nx = st[k];
        nx.n = st[k].sqp[0] + st[k].sqp[1] + st[k].sqp[2];
        nx.sr = '0;
        nx.sq = '0;
        nx.cx = Q30_GAIN;
        nx.cy = '0;
        nx.cz = st[k].th;
      end
    end else if (k < DIV0) begin : g_sqrt
      localparam int J = k - SQRT0;
      localparam int D = 31 - J;
      always_comb begin
        logic [35:0] rr;
        logic [35:0] tt;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [35:0] at;
        nx = st[k];
        rr = {st[k].sr[33:0], st[k].n[2*D+1 -: 2]};
        tt = {2'b00, st[k].sq, 2'b01};
        if (rr >= tt) begin
          nx.sr = rr - tt;
          nx.sq = {st[k].sq[30:0], 1'b1};
        end else begin
          nx.sr = rr;
          nx.sq = {st[k].sq[30:0], 1'b0};
        end
        dx = st[k].cx >>> J;
        dy = st[k].cy >>> J;
        at = {4'd0, atan_q30(5'(J))};
        if (J < CORDIC_STEPS) begin
          if (st[k].cz >= 0) begin
            nx.cx = st[k].cx - dy;
            nx.cy = st[k].cy + dx;
            nx.cz = st[k].cz - at;
          end else begin
            nx.cx = st[k].cx + dy;
            nx.cy = st[k].cy - dx;
            nx.cz = st[k].cz + at;
          end
        end
      end
    end else begin : g_div
      localparam int J = k - DIV0;
      always_comb begin
        logic [32:0] rem2;
        logic        qb;
        nx = st[k];
        for (int i = 0; i < 3; i++) begin
          rem2 = (J == 0) ? {1'b0, st[k].mag[i]} : {st[k].dr[i], 1'b0};
          qb = (rem2 >= {1'b0, st[k].sq});
          nx.dr[i] = qb ? 32'(rem2 - {1'b0, st[k].sq}) : rem2[31:0];
          nx.dq[i] = {st[k].dq[i][29:0], qb};
        end
      end
    end

    always_ff @(posedge clk) begin
      st[k+1] <= nx;
      if (rst) v[k+1] <= 1'b0;
      else v[k+1] <= v[k];
    end
  end

  logic               m0_v, m1_v, m2_v, m3_v, m4_v, m5_v;
  logic               m0_deg, m1_deg, m2_deg, m3_deg, m4_deg, m5_deg;
  logic signed [31:0] m0_u [3];
  logic signed [33:0] m0_cs, m0_sn, m1_cs, m2_cs;
  logic signed [34:0] m0_omc, m1_omc;
  logic signed [31:0] m0_cen [3];
  logic signed [31:0] m1_cen [3];
  logic signed [31:0] m2_cen [3];
  logic signed [31:0] m3_cen [3];
  logic signed [31:0] m4_cen [3];
  logic signed [63:0] m1_p [6];
  logic signed [65:0] m1_q [3];
  logic signed [31:0] m1_uu [6];
  logic signed [35:0] m1_us [3];
  logic signed [35:0] m2_us [3];
  logic signed [66:0] m2_p [6];
  logic signed [35:0] m2_t [6];
  logic signed [35:0] m3_rot [9];
  logic signed [67:0] m4_p [9];
  logic signed [53:0] m4_rp [9];
  logic [31:0]        m4_ro_next [9];
  logic [31:0]        m4_ro [9];
  logic [31:0]        m5_ro [9];
  logic [31:0]        m5_tr_next [3];
  logic [31:0]        m5_tr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m0_v <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
      m5_v <= 1'b0;
    end else begin
      m0_v <= v[NS];
      m1_v <= m0_v;
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
      m5_v <= m4_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m0_u[i] <= st[NS].neg[i] ? -$signed({1'b0, st[NS].dq[i]})
                               : $signed({1'b0, st[NS].dq[i]});
      m0_cen[i] <= st[NS].cen[i];
    end
    m0_cs <= st[NS].flip ? -st[NS].cx : st[NS].cx;
    m0_sn <= st[NS].cy;
    m0_omc <= 35'(Q30_ONE) - (st[NS].flip ? -35'(st[NS].cx) : 35'(st[NS].cx));
    m0_deg <= st[NS].deg;
  end

  always_comb begin
    m1_p[0] = m0_u[0] * m0_u[0];
    m1_p[1] = m0_u[0] * m0_u[1];
    m1_p[2] = m0_u[0] * m0_u[2];
    m1_p[3] = m0_u[1] * m0_u[1];
    m1_p[4] = m0_u[1] * m0_u[2];
    m1_p[5] = m0_u[2] * m0_u[2];
    for (int i = 0; i < 3; i++) m1_q[i] = m0_u[i] * m0_sn;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) m1_uu[j] <= m1_p[j][61:30];
    for (int i = 0; i < 3; i++) begin
      m1_us[i] <= m1_q[i][65:30];
      m1_cen[i] <= m0_cen[i];
    end
    m1_cs <= m0_cs;
    m1_omc <= m0_omc;
    m1_deg <= m0_deg;
  end

  always_comb begin
    for (int j = 0; j < 6; j++) m2_p[j] = m1_uu[j] * m1_omc;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) m2_t[j] <= m2_p[j][65:30];
    for (int i = 0; i < 3; i++) begin
      m2_us[i] <= m1_us[i];
      m2_cen[i] <= m1_cen[i];
    end
    m2_cs <= m1_cs;
    m2_deg <= m1_deg;
  end

  always_ff @(posedge clk) begin
    m3_rot[0] <= 36'(m2_cs) + m2_t[0];
    m3_rot[1] <= m2_t[1] - m2_us[2];
    m3_rot[2] <= m2_t[2] + m2_us[1];
    m3_rot[3] <= m2_t[1] + m2_us[2];
    m3_rot[4] <= 36'(m2_cs) + m2_t[3];
    m3_rot[5] <= m2_t[4] - m2_us[0];
    m3_rot[6] <= m2_t[2] - m2_us[1];
    m3_rot[7] <= m2_t[4] + m2_us[0];
    m3_rot[8] <= 36'(m2_cs) + m2_t[5];
    for (int i = 0; i < 3; i++) m3_cen[i] <= m2_cen[i];
    m3_deg <= m2_deg;
  end

  always_comb begin
    logic signed [36:0] rs;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        m4_p[i*3+k] = m3_rot[i*3+k] * m3_cen[k];
      end
    end
    for (int e = 0; e < 9; e++) begin
      rs = 37'(m3_rot[e]) + RND;
      m4_ro_next[e] = sat32(56'(rs >>> RND_SH));
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      m4_rp[e] <= m4_p[e][67:14];
      m4_ro[e] <= m4_ro_next[e];
    end
    for (int i = 0; i < 3; i++) m4_cen[i] <= m3_cen[i];
    m4_deg <= m3_deg;
  end

  always_comb begin
    logic signed [55:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = (56'(m4_cen[i]) <<< 16) - 56'(m4_rp[i*3]) - 56'(m4_rp[i*3+1])
            - 56'(m4_rp[i*3+2]);
      m5_tr_next[i] = sat32((acc + 56'sd32768) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) m5_ro[e] <= m4_ro[e];
    for (int i = 0; i < 3; i++) m5_tr[i] <= m5_tr_next[i];
    m5_deg <= m4_deg;
  end

  always_comb begin
    out_mat.deg = m5_deg;
    for (int e = 0; e < 9; e++) out_mat.rv[e] = m5_ro[e];
    for (int i = 0; i < 3; i++) out_mat.tv[i] = m5_tr[i];
  end

  assign out_valid = m5_v;

endmodule

// ===== rtl/axis_angle_rotation_about_point.sv =====
// Rotation about a point: builds the 4x4 homogeneous matrix T(c)*R*T(-c).
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; request carries axis, angle (Q4.28) and center.
// Result channel: result_valid marks each result for one cycle. A normal
// transaction yields 16 elements in row-major order, last on element 15;
// a zero axis yields one result with degenerate and last set.
// The compute path is a 77-stage pipeline (normalize, square root and
// divide one bit per stage, CORDIC in step with the square root, then the
// matrix multiplies); a new command may enter every cycle while busy is low.
// The single result port, moving one element a cycle, limits how often
// transactions can complete. Finished matrices wait in an 8-entry buffer;
// busy rises while 7 transactions are in flight.
// The receiver cannot stall; results leave as they are produced.
// Reset (synchronous, active high) empties the pipeline and the buffer and
// drops busy; no state survives between transactions.
module axis_angle_rotation_about_point import aar_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  request,
  output logic busy,
  output logic result_valid,
  output out_t result
);

  localparam int PIPE_LAT = 80;
  localparam int CREDITS = PIPE_LAT / ELEMS + 2;
  localparam int AW = $clog2(CREDITS);
  localparam int FDEPTH = 1 << AW;
  localparam int CW = $clog2(CREDITS + 1);
  localparam logic [31:0] ONE_OUT = 32'd1 << FRAC_BITS;

  logic            accept;
  logic            pipe_valid;
  mat_t            pipe_mat;
  logic [CW-1:0]   inflight;
  logic [CW-1:0]   inflight_next;
  mat_t            mem [FDEPTH];
  logic [AW:0]     wptr, rptr;
  logic            fifo_empty, fifo_full;
  mat_t            cur;
  logic            cur_full;
  logic [ELEM_W-1:0] ecnt;
  logic            fin, load;
  out_t            elem;
  logic [3:0]      ri;

  assign busy = (inflight == CW'(CREDITS));
  assign accept = start && !busy;

  aar_pipe #(
    .FRAC_BITS(FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_pipe (
    .clk(clk),
    .rst(rst),
    .in_valid(accept),
    .in_item(request),
    .out_valid(pipe_valid),
    .out_mat(pipe_mat)
  );

  assign fifo_empty = (wptr == rptr);
  assign fifo_full = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign fin = cur_full && (cur.deg || ecnt == ELEM_W'(ELEMS - 1));
  assign load = !fifo_empty && (!cur_full || fin);
  assign inflight_next = inflight + CW'(accept) - CW'(fin);

  always_ff @(posedge clk) begin
    if (pipe_valid) mem[wptr[AW-1:0]] <= pipe_mat;
    if (load) cur <= mem[rptr[AW-1:0]];
  end

  always_comb begin
    ri = {1'b0, ecnt[3:2], 1'b0} + {2'b00, ecnt[3:2]} + {2'b00, ecnt[1:0]};
    elem.row = ecnt[3:2];
    elem.col = ecnt[1:0];
    elem.degenerate = 1'b0;
    elem.last = (ecnt == ELEM_W'(ELEMS - 1));
    if (ecnt[3:2] == 2'd3) elem.value = (ecnt[1:0] == 2'd3) ? ONE_OUT : 32'd0;
    else if (ecnt[1:0] == 2'd3) elem.value = cur.tv[ecnt[3:2]];
    else elem.value = cur.rv[ri];
    if (cur.deg) begin
      elem.row = 2'd0;
      elem.col = 2'd0;
      elem.value = 32'd0;
      elem.degenerate = 1'b1;
      elem.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
      wptr <= '0;
      rptr <= '0;
      cur_full <= 1'b0;
      ecnt <= '0;
      result_valid <= 1'b0;
    end else begin
      inflight <= inflight_next;
      if (pipe_valid) wptr <= wptr + 1'b1;
      if (load) rptr <= rptr + 1'b1;
      if (load) cur_full <= 1'b1;
      else if (fin) cur_full <= 1'b0;
      if (fin) ecnt <= '0;
      else if (cur_full) ecnt <= ecnt + 1'b1;
      result_valid <= cur_full;
    end
  end

  always_ff @(posedge clk) begin
    result <= elem;
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(CREDITS))
    else $error("in-flight count above credit limit");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> !fifo_full)
    else $error("matrix buffer written while full");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("gap inside a matrix burst");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> fifo_empty && !cur_full)
    else $error("data held with no transaction in flight");

  a_deg_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> result.last)
    else $error("degenerate result without last");

endmodule
